// ----- design/fnu_pkg.sv -----
// Shared constants for the face normal unit.
package fnu_pkg;

    // a face needs this many corners to define a plane
    localparam logic [7:0] MIN_CORNERS = 8'd3;

    // flags that travel with each item down the pipe
    typedef struct packed {
        logic vld;
        logic few;
        logic zero;
        logic last;
    } t_tag;

endpackage

// ----- design/fnu_step.sv -----
// One registered restoring step of the quotient-by-root search for one component.
module fnu_step #(
    parameter int RW  = 100,
    parameter int QW  = 15,
    parameter int BIT = 14
) (
    input  logic          i_clk,
    input  logic [RW-1:0] i_r,
    input  logic [RW-1:0] i_p,
    input  logic [RW-1:0] i_s,
    input  logic [QW-1:0] i_q,
    output logic [RW-1:0] o_r,
    output logic [RW-1:0] o_p,
    output logic [QW-1:0] o_q
);

    logic [RW-1:0] w_test;
    logic          w_take;
    logic [RW-1:0] n_r;
    logic [RW-1:0] n_p;
    logic [QW-1:0] n_q;
    logic [RW-1:0] r_r;
    logic [RW-1:0] r_p;
    logic [QW-1:0] r_q;

    // (q + 2^b)^2 S - q^2 S = 2^(b+1) qS + 2^(2b) S, with p = qS
    assign w_test = (i_p << (BIT + 1)) + (i_s << (2 * BIT));
    assign w_take = (i_r >= w_test);

    always_comb begin
        n_r = i_r;
        n_p = i_p;
        n_q = i_q;
        if (w_take) begin
            n_r = i_r - w_test;
            n_p = i_p + (i_s << BIT);
            n_q = i_q | (QW'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r;
        r_p <= n_p;
        r_q <= n_q;
    end

    assign o_r = r_r;
    assign o_p = r_p;
    assign o_q = r_q;

endmodule

// ----- design/face_normal_unit.sv -----
// Top level of the face normal unit: cross product and normalize pipeline.
//
// Drive the three corners, corner_count and last_face with i_start high for
// one cycle per face; the face is taken at every edge where i_start is high
// and o_busy is low. o_busy is always low, so a face can enter every cycle.
// Each result appears on the o_normal_* and flag ports for exactly one
// cycle, marked by o_valid, in the order the faces entered.
// Five stages form edges, products, the cross product, its squares and the
// squared length, then one stage per quotient bit, then the output register.
// Throughput is one face per cycle; each quotient bit has its own stage.
// Faces with fewer than three corners give (1.0, 1.0, 1.0) and few_corners;
// a zero cross product gives a zero normal and zero_length.
// Reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall: a result not taken in its cycle is gone.
module face_normal_unit #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_az,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_bz,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_cz,
    input  logic [7:0]                    i_corner_count,
    input  logic                          i_last_face,
    output logic                          o_valid,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_z,
    output logic                          o_few_corners,
    output logic                          o_zero_length,
    output logic                          o_last_out
);

    localparam int CW = COORD_WIDTH;
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int EW = CW + 1;          // edge
    localparam int PW = 2 * EW;          // edge product
    localparam int DW = PW + 1;          // cross product component, signed
    localparam int MW = PW;              // its magnitude
    localparam int SW = 2 * MW + 2;      // squared length
    localparam int RW = SW + 2 * F + 2;  // remainder and qS
    localparam int QW = F + 1;
    localparam int OW = F + 2;
    localparam int NS = F + 1;           // quotient steps

    // stage 1: edges
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    // stage 2: products
    logic signed [PW-1:0] r_pr [6];
    // stage 3: magnitude and sign of the cross product
    logic [MW-1:0] r_mag [3];
    logic          r_neg3 [3];
    // stage 4: squares
    logic [2*MW-1:0] r_sq [3];
    logic            r_neg4 [3];
    // stage 5: squared length and scaled targets
    logic [RW-1:0] r_s;
    logic [RW-1:0] r_t [3];
    logic          r_neg5 [3];

    fnu_pkg::t_tag r_tag [1:5];
    fnu_pkg::t_tag r_ctag [1:NS];
    logic          r_cneg [3][1:NS];
    logic [RW-1:0] r_cs [1:NS-1];

    logic [RW-1:0] w_r [3][NS+1];
    logic [RW-1:0] w_p [3][NS+1];
    logic [QW-1:0] w_q [3][NS+1];

    fnu_pkg::t_tag n_tag1;
    logic [SW-1:0] n_s;
    logic signed [DW-1:0] n_d [3];

    assign o_busy = 1'b0;

    always_comb begin
        n_tag1.vld  = i_start;
        n_tag1.few  = (i_corner_count < fnu_pkg::MIN_CORNERS);
        n_tag1.zero = 1'b0;
        n_tag1.last = i_last_face;
    end

    always_ff @(posedge i_clk) begin
        r_e1[0] <= EW'(i_bx) - EW'(i_ax);
        r_e1[1] <= EW'(i_by) - EW'(i_ay);
        r_e1[2] <= EW'(i_bz) - EW'(i_az);
        r_e2[0] <= EW'(i_cx) - EW'(i_ax);
        r_e2[1] <= EW'(i_cy) - EW'(i_ay);
        r_e2[2] <= EW'(i_cz) - EW'(i_az);
    end

    always_ff @(posedge i_clk) begin
        r_pr[0] <= PW'(r_e1[1] * r_e2[2]);
        r_pr[1] <= PW'(r_e1[2] * r_e2[1]);
        r_pr[2] <= PW'(r_e1[2] * r_e2[0]);
        r_pr[3] <= PW'(r_e1[0] * r_e2[2]);
        r_pr[4] <= PW'(r_e1[0] * r_e2[1]);
        r_pr[5] <= PW'(r_e1[1] * r_e2[0]);
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_d[l] = DW'(r_pr[2*l]) - DW'(r_pr[2*l+1]);
        end
        n_s = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_neg3[l] <= n_d[l][DW-1];
            r_mag[l]  <= n_d[l][DW-1] ? MW'(-n_d[l]) : MW'(n_d[l]);
            r_neg4[l] <= r_neg3[l];
            r_sq[l]   <= r_mag[l] * r_mag[l];
            r_neg5[l] <= r_neg4[l];
            r_t[l]    <= RW'(r_sq[l]) << (2 * F);
        end
        r_s <= RW'(n_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 5; k++) r_tag[k] <= '0;
        end else begin
            r_tag[1] <= n_tag1;
            for (int k = 2; k <= 4; k++) r_tag[k] <= r_tag[k-1];
            r_tag[5].vld  <= r_tag[4].vld;
            r_tag[5].few  <= r_tag[4].few;
            r_tag[5].zero <= (n_s == '0);
            r_tag[5].last <= r_tag[4].last;
        end
    end

    // quotient chain, one bit per stage, msb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NS; k++) r_ctag[k] <= '0;
        end else begin
            r_ctag[1] <= r_tag[5];
            for (int k = 2; k <= NS; k++) r_ctag[k] <= r_ctag[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cs[1] <= r_s;
        for (int k = 2; k <= NS - 1; k++) r_cs[k] <= r_cs[k-1];
        for (int l = 0; l < 3; l++) begin
            r_cneg[l][1] <= r_neg5[l];
            for (int k = 2; k <= NS; k++) r_cneg[l][k] <= r_cneg[l][k-1];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_r[l][0] = r_t[l];
        assign w_p[l][0] = '0;
        assign w_q[l][0] = '0;
        for (genvar k = 0; k < NS; k++) begin : g_bit
            fnu_step #(
                .RW (RW),
                .QW (QW),
                .BIT(F - k)
            ) u_step (
                .i_clk(i_clk),
                .i_r  (w_r[l][k]),
                .i_p  (w_p[l][k]),
                .i_s  ((k == 0) ? r_s : r_cs[(k == 0) ? 1 : k]),
                .i_q  (w_q[l][k]),
                .o_r  (w_r[l][k+1]),
                .o_p  (w_p[l][k+1]),
                .o_q  (w_q[l][k+1])
            );
        end
    end

    logic [OW-1:0] n_out [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_ctag[NS].few) begin
                n_out[l] = OW'(1) << F;
            end else if (r_ctag[NS].zero) begin
                n_out[l] = '0;
            end else if (r_cneg[l][NS]) begin
                n_out[l] = OW'(-OW'(w_q[l][NS]));
            end else begin
                n_out[l] = OW'(w_q[l][NS]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_ctag[NS].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_normal_x    <= n_out[0];
        o_normal_y    <= n_out[1];
        o_normal_z    <= n_out[2];
        o_few_corners <= r_ctag[NS].few;
        o_zero_length <= r_ctag[NS].zero & ~r_ctag[NS].few;
        o_last_out    <= r_ctag[NS].last;
    end

endmodule

// ----- bench/face_normal_unit_tb.sv -----
// Self-checking bench for the face normal unit: cross product, normalize, flags.
module face_normal_unit_tb;

    localparam int CW        = 16;
    localparam int FB        = 14;
    localparam int OW        = FB + 2;
    localparam int LATENCY   = FB + 7;
    localparam int MAX_CYCLES = 200000;

    typedef struct {
        logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [7:0]           corners;
        logic                 last;
    } t_face;

    typedef struct {
        logic signed [OW-1:0] nx, ny, nz;
        logic                 few, zero, last;
    } t_normal;

    logic                 i_clk, i_rst_n, i_start;
    logic                 o_busy, o_valid;
    logic signed [CW-1:0] i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_cx, i_cy, i_cz;
    logic [7:0]           i_corner_count;
    logic                 i_last_face;
    logic signed [OW-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic                 o_few_corners, o_zero_length, o_last_out;

    t_normal pending_normals[$];
    int      fail_count, face_count, checked_count, few_seen, zero_seen, cycle_count;
    int      idle_pct;

    face_normal_unit #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_ax(i_ax), .i_ay(i_ay), .i_az(i_az), .i_bx(i_bx), .i_by(i_by),
        .i_bz(i_bz), .i_cx(i_cx), .i_cy(i_cy), .i_cz(i_cz),
        .i_corner_count(i_corner_count), .i_last_face(i_last_face),
        .o_valid(o_valid), .o_normal_x(o_normal_x), .o_normal_y(o_normal_y),
        .o_normal_z(o_normal_z), .o_few_corners(o_few_corners),
        .o_zero_length(o_zero_length), .o_last_out(o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // truncated |n| * 2^FB / sqrt(len_sq) found bit by bit, sign applied after
    function automatic logic signed [OW-1:0] unit_component(longint n, logic [127:0] len_sq);
        logic [127:0] mag, target, cand, q;
        mag    = (n < 0) ? 128'(-n) : 128'(n);
        target = (mag * mag) << (2 * FB);
        q      = '0;
        for (int b = FB; b >= 0; b--) begin
            cand = q | (128'd1 << b);
            if (cand * cand * len_sq <= target) q = cand;
        end
        return (n < 0) ? OW'(-q) : OW'(q);
    endfunction

    function automatic t_normal face_normal(t_face f);
        t_normal      r;
        longint       e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        logic [127:0] mx, my, mz, len_sq;
        r.last = f.last;
        r.few  = 1'b0;
        r.zero = 1'b0;
        if (f.corners < fnu_pkg::MIN_CORNERS) begin
            r.few = 1'b1;
            r.nx  = OW'(1 << FB);
            r.ny  = OW'(1 << FB);
            r.nz  = OW'(1 << FB);
            return r;
        end
        e1x = longint'(f.bx) - f.ax; e1y = longint'(f.by) - f.ay; e1z = longint'(f.bz) - f.az;
        e2x = longint'(f.cx) - f.ax; e2y = longint'(f.cy) - f.ay; e2z = longint'(f.cz) - f.az;
        nx = e1y * e2z - e1z * e2y;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        mx = (nx < 0) ? 128'(-nx) : 128'(nx);
        my = (ny < 0) ? 128'(-ny) : 128'(ny);
        mz = (nz < 0) ? 128'(-nz) : 128'(nz);
        len_sq = mx * mx + my * my + mz * mz;
        if (len_sq == 0) begin
            r.zero = 1'b1;
            r.nx = '0; r.ny = '0; r.nz = '0;
            return r;
        end
        r.nx = unit_component(nx, len_sq);
        r.ny = unit_component(ny, len_sq);
        r.nz = unit_component(nz, len_sq);
        return r;
    endfunction

    task automatic drive_idle();
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    task automatic send_face(t_face f);
        while ($urandom_range(99) < idle_pct) drive_idle();
        @(negedge i_clk);
        i_start = 1'b1;
        i_ax = f.ax; i_ay = f.ay; i_az = f.az;
        i_bx = f.bx; i_by = f.by; i_bz = f.bz;
        i_cx = f.cx; i_cy = f.cy; i_cz = f.cz;
        i_corner_count = f.corners;
        i_last_face    = f.last;
        // busy only moves on the rising edge, so its value here holds at the edge
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_normals.push_back(face_normal(f));
        face_count++;
    endtask

    function automatic t_face make_face(int a0, int a1, int a2, int b0, int b1, int b2,
                                        int c0, int c1, int c2, int n, int last);
        t_face f;
        f.ax = CW'(a0); f.ay = CW'(a1); f.az = CW'(a2);
        f.bx = CW'(b0); f.by = CW'(b1); f.bz = CW'(b2);
        f.cx = CW'(c0); f.cy = CW'(c1); f.cz = CW'(c2);
        f.corners = 8'(n);
        f.last    = 1'(last);
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_normal exp_n;
        if (i_rst_n && o_valid) begin
            if (pending_normals.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                         o_normal_x, o_normal_y, o_normal_z);
                fail_count++;
            end else begin
                exp_n = pending_normals.pop_front();
                checked_count++;
                if (exp_n.few) few_seen++;
                if (exp_n.zero) zero_seen++;
                if (o_normal_x !== exp_n.nx || o_normal_y !== exp_n.ny ||
                    o_normal_z !== exp_n.nz || o_few_corners !== exp_n.few ||
                    o_zero_length !== exp_n.zero || o_last_out !== exp_n.last) begin
                    $display("%0t: mismatch expected (%0d,%0d,%0d) few=%b zero=%b last=%b",
                             $time, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.few, exp_n.zero,
                             exp_n.last);
                    $display("%0t:          actual   (%0d,%0d,%0d) few=%b zero=%b last=%b",
                             $time, o_normal_x, o_normal_y, o_normal_z, o_few_corners,
                             o_zero_length, o_last_out);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_few_corners();
        send_face(make_face(1, 2, 3, 4, 5, 6, 7, 8, 9, 0, 0));
        send_face(make_face(-32768, 32767, 0, 5, 5, 5, 9, 9, 9, 1, 1));
        send_face(make_face(0, 0, 0, 256, 0, 0, 0, 256, 0, 2, 0));
    endtask

    task automatic test_axis_faces();
        send_face(make_face(0, 0, 0, 256, 0, 0, 0, 256, 0, 3, 0));
        send_face(make_face(0, 0, 0, 0, 256, 0, 256, 0, 0, 3, 1));
        send_face(make_face(0, 0, 0, 0, 0, 256, 256, 0, 0, 255, 0));
        send_face(make_face(0, 0, 0, 0, 1, 0, 0, 0, 1, 4, 0));
        send_face(make_face(0, 0, 0, 256, 256, 0, 0, 256, 256, 3, 0));
        send_face(make_face(0, 0, 0, 1, 1, 1, 1, -1, 0, 3, 1));
    endtask

    task automatic test_zero_length();
        send_face(make_face(7, 7, 7, 7, 7, 7, 7, 7, 7, 3, 0));
        send_face(make_face(0, 0, 0, 100, 200, 300, 200, 400, 600, 3, 1));
        send_face(make_face(-32768, -32768, -32768, 32767, 32767, 32767,
                            0, 0, 0, 200, 0));
        send_face(make_face(5, 5, 5, 5, 5, 5, 100, -3, 8, 3, 0));
    endtask

    task automatic test_coord_extremes();
        send_face(make_face(-32768, -32768, -32768, 32767, -32768, -32768,
                            -32768, 32767, -32768, 3, 0));
        send_face(make_face(32767, 32767, 32767, -32768, 32767, 32767,
                            32767, -32768, 32767, 3, 1));
        send_face(make_face(-32768, 32767, -32768, 32767, -32768, 32767,
                            32767, 32767, -32768, 255, 0));
        send_face(make_face(0, 0, 0, 32767, -32768, 1, -32768, 1, 32767, 3, 1));
        send_face(make_face(-1, -1, -1, 0, -1, -1, -1, 0, -1, 3, 0));
    endtask

    function automatic t_face random_face();
        t_face f;
        int    sel, k, dx, dy, dz;
        sel = $urandom_range(99);
        f   = make_face($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom_range(255, 3),
                        $urandom_range(1));
        if (sel < 20) begin
            // tiny coordinates often land on coarse or degenerate geometry
            f = make_face($urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(8) - 4,
                          $urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(8) - 4,
                          $urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(8) - 4,
                          $urandom_range(255, 3), $urandom_range(1));
        end else if (sel < 30) begin
            dx = $urandom_range(2000) - 1000;
            dy = $urandom_range(2000) - 1000;
            dz = $urandom_range(2000) - 1000;
            k  = $urandom_range(6) - 3;
            f.ax = CW'($urandom_range(20000) - 10000);
            f.ay = CW'($urandom_range(20000) - 10000);
            f.az = CW'($urandom_range(20000) - 10000);
            f.bx = f.ax + CW'(dx); f.by = f.ay + CW'(dy); f.bz = f.az + CW'(dz);
            f.cx = f.ax + CW'(k * dx); f.cy = f.ay + CW'(k * dy); f.cz = f.az + CW'(k * dz);
        end else if (sel < 40) begin
            f.corners = 8'($urandom_range(2));
        end else if (sel < 44) begin
            f.bx = f.ax; f.by = f.ay; f.bz = f.az;
        end
        return f;
    endfunction

    task automatic test_random(int count, int pct);
        idle_pct = pct;
        repeat (count) send_face(random_face());
        idle_pct = 0;
    endtask

    initial begin
        int drain;
        fail_count = 0; face_count = 0; checked_count = 0;
        few_seen = 0; zero_seen = 0; cycle_count = 0; idle_pct = 0;
        i_rst_n = 1'b0; i_start = 1'b0;
        i_ax = '0; i_ay = '0; i_az = '0; i_bx = '0; i_by = '0; i_bz = '0;
        i_cx = '0; i_cy = '0; i_cz = '0;
        i_corner_count = '0; i_last_face = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_few_corners();
        test_axis_faces();
        test_zero_length();
        test_coord_extremes();
        test_random(200, 0);
        test_random(130, 74);
        test_random(170, 12);
        drive_idle();

        drain = 0;
        while (pending_normals.size() != 0 && drain < 10 * LATENCY) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);

        $display("sent %0d faces, checked %0d normals (%0d few-corner, %0d zero-length)",
                 face_count, checked_count, few_seen, zero_seen);
        $display("%0d normals still outstanding, %0d mismatches",
                 pending_normals.size(), fail_count);
        if (fail_count == 0 && pending_normals.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
